@@ sv/assert_macros.svh @@
// Concurrent assertion helpers, clocked on clk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/crsp_pkg.sv @@
package crsp_pkg;

  localparam int PIX_W = 8;
  localparam int SEL_W = 2;

  typedef logic [PIX_W-1:0] pix_t;

  typedef enum logic [SEL_W-1:0] {
    ANG_45  = 2'd0,
    ANG_135 = 2'd1,
    ANG_225 = 2'd2
  } angle_t;

  // RGB to YUV, Q16
  localparam int KY_R    = 19611;
  localparam int KY_G    = 38459;
  localparam int KY_B    = 7478;
  localparam int KU_R    = 32898;
  localparam int KU_G    = 27578;
  localparam int KU_B    = 5320;
  localparam int KV_R    = 11091;
  localparam int KV_G    = 21807;
  localparam int KV_B    = 32898;
  localparam int RND_FWD = 32767;

  // YUV to RGB, Q16
  localparam int K_LUMA  = 65514;
  localparam int KR_U    = 91469;
  localparam int KG_U    = 46594;
  localparam int KG_V    = 22408;
  localparam int KB_V    = 115655;
  localparam int RND_INV = 32768;

  // floor(x/3) = (x * RECIP3) >> 16 for the small values seen here
  localparam int RECIP3  = 21846;

endpackage

@@ sv/crsp_if.sv @@
interface crsp_in_if;
  logic                        valid;
  logic                        ready;
  logic [crsp_pkg::PIX_W-1:0]  red_in;
  logic [crsp_pkg::PIX_W-1:0]  green_in;
  logic [crsp_pkg::PIX_W-1:0]  blue_in;
  logic [crsp_pkg::SEL_W-1:0]  angle_select;

  modport source (output valid, red_in, green_in, blue_in, angle_select, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, angle_select, output ready);
endinterface

interface crsp_out_if;
  logic                        valid;
  logic                        ready;
  logic [crsp_pkg::PIX_W-1:0]  red_out;
  logic [crsp_pkg::PIX_W-1:0]  green_out;
  logic [crsp_pkg::PIX_W-1:0]  blue_out;

  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

interface crsp_cfg_if;
  logic valid;
  logic ready;
  logic chroma_scramble_enable;

  modport source (output valid, chroma_scramble_enable, input ready);
  modport sink   (input valid, chroma_scramble_enable, output ready);
endinterface

@@ sv/chroma_rotate_scramble_pixel.sv @@
// Channel  Direction  Contents
// in_ch    sink       red_in, green_in, blue_in, angle_select
// out_ch   source     red_out, green_out, blue_out
// cfg_ch   sink       chroma_scramble_enable (always ready)
//
// One pixel a cycle while out_ch is not stalled; input passes to output through the
// RGB-to-YUV, rotation, divide-by-three and YUV-to-RGB register stages.
// Reset clears all stage valid bits and sets the enable register.
// Each stage holds its word only while the stage ahead is full and stalled,
// so bubbles close up and in_ch.ready drops only when all stages are full.
`include "assert_macros.svh"

module chroma_rotate_scramble_pixel (
  input  logic      clk,
  input  logic      rst_n,
  crsp_in_if.sink   in_ch,
  crsp_out_if.source out_ch,
  crsp_cfg_if.sink  cfg_ch
);

  localparam int W = crsp_pkg::PIX_W;

  function automatic logic [W-1:0] chroma_fwd(
    input logic [W-1:0] a,
    input logic [W-1:0] b,
    input logic [W-1:0] c,
    input logic [16:0]  ka,
    input logic [16:0]  kb,
    input logic [16:0]  kc
  );
    logic signed [26:0] acc;
    logic signed [10:0] q;
    acc = $signed({10'b0, ka}) * $signed({19'b0, a})
        - $signed({10'b0, kb}) * $signed({19'b0, b})
        - $signed({10'b0, kc}) * $signed({19'b0, c})
        + 27'(crsp_pkg::RND_FWD);
    q = 11'(acc >>> 16) + 11'sd128;
    if (q < 0) begin
      chroma_fwd = '0;
    end else if (q > 11'sd255) begin
      chroma_fwd = '1;
    end else begin
      chroma_fwd = q[W-1:0];
    end
  endfunction

  function automatic logic [W-1:0] clamp_q16(input logic signed [26:0] acc);
    logic signed [10:0] q;
    q = 11'(acc >>> 16);
    if (q < 0) begin
      clamp_q16 = '0;
    end else if (q > 11'sd255) begin
      clamp_q16 = '1;
    end else begin
      clamp_q16 = q[W-1:0];
    end
  endfunction

  // configuration
  logic enable_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
    end else if (cfg_ch.valid) begin
      enable_r <= cfg_ch.chroma_scramble_enable;
    end
  end

  // stage flow control
  logic s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  logic adv1, adv2, adv3, adv4;

  assign adv4 = !out_valid_r || out_ch.ready;
  assign adv3 = !s3_valid_r || adv4;
  assign adv2 = !s2_valid_r || adv3;
  assign adv1 = !s1_valid_r || adv2;
  assign in_ch.ready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv1) begin
        s1_valid_r <= in_ch.valid;
      end
      if (adv2) begin
        s2_valid_r <= s1_valid_r;
      end
      if (adv3) begin
        s3_valid_r <= s2_valid_r;
      end
      if (adv4) begin
        out_valid_r <= s3_valid_r;
      end
    end
  end

  // stage 1: RGB to YUV
  logic [24:0]  y_sum;
  logic [W-1:0] y_nxt, u_nxt, v_nxt;

  assign y_sum = 25'(crsp_pkg::KY_R) * 25'(in_ch.red_in)
               + 25'(crsp_pkg::KY_G) * 25'(in_ch.green_in)
               + 25'(crsp_pkg::KY_B) * 25'(in_ch.blue_in)
               + 25'(crsp_pkg::RND_FWD);
  assign y_nxt = y_sum[23:16];
  assign u_nxt = chroma_fwd(in_ch.red_in, in_ch.green_in, in_ch.blue_in,
                            17'(crsp_pkg::KU_R), 17'(crsp_pkg::KU_G),
                            17'(crsp_pkg::KU_B));
  assign v_nxt = chroma_fwd(in_ch.blue_in, in_ch.red_in, in_ch.green_in,
                            17'(crsp_pkg::KV_B), 17'(crsp_pkg::KV_R),
                            17'(crsp_pkg::KV_G));

  logic                       s1_byp_r;
  logic [W-1:0]               s1_r_r, s1_g_r, s1_b_r;
  logic [W-1:0]               s1_y_r, s1_u_r, s1_v_r;
  logic [crsp_pkg::SEL_W-1:0] s1_sel_r;

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_byp_r <= !enable_r;
      s1_r_r   <= in_ch.red_in;
      s1_g_r   <= in_ch.green_in;
      s1_b_r   <= in_ch.blue_in;
      s1_sel_r <= in_ch.angle_select;
      s1_y_r   <= y_nxt;
      s1_u_r   <= u_nxt;
      s1_v_r   <= v_nxt;
    end
  end

  // stage 2: rotation
  logic [9:0] ut_nxt, vt_nxt;

  crsp_rotate u_rotate (
    .u      (s1_u_r),
    .v      (s1_v_r),
    .sel    (crsp_pkg::angle_t'(s1_sel_r)),
    .ut_ofs (ut_nxt),
    .vt_ofs (vt_nxt)
  );

  logic         s2_byp_r;
  logic [W-1:0] s2_r_r, s2_g_r, s2_b_r, s2_y_r;
  logic [9:0]   s2_ut_r, s2_vt_r;

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_byp_r <= s1_byp_r;
      s2_r_r   <= s1_r_r;
      s2_g_r   <= s1_g_r;
      s2_b_r   <= s1_b_r;
      s2_y_r   <= s1_y_r;
      s2_ut_r  <= ut_nxt;
      s2_vt_r  <= vt_nxt;
    end
  end

  // stage 3: desaturate, divide by three through the reciprocal
  logic [24:0]       ud_prod, vd_prod;
  logic signed [8:0] ud_nxt, vd_nxt;

  assign ud_prod = 25'(s2_ut_r) * 25'(crsp_pkg::RECIP3);
  assign vd_prod = 25'(s2_vt_r) * 25'(crsp_pkg::RECIP3);
  assign ud_nxt  = $signed({1'b0, ud_prod[23:16]} - 9'd128);
  assign vd_nxt  = $signed({1'b0, vd_prod[23:16]} - 9'd128);

  logic              s3_byp_r;
  logic [W-1:0]      s3_r_r, s3_g_r, s3_b_r, s3_y_r;
  logic signed [8:0] s3_ud_r, s3_vd_r;

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_byp_r <= s2_byp_r;
      s3_r_r   <= s2_r_r;
      s3_g_r   <= s2_g_r;
      s3_b_r   <= s2_b_r;
      s3_y_r   <= s2_y_r;
      s3_ud_r  <= ud_nxt;
      s3_vd_r  <= vd_nxt;
    end
  end

  // stage 4: YUV to RGB, clamp, pick bypass
  logic signed [26:0] luma;
  logic signed [26:0] r_acc, g_acc, b_acc;
  logic [W-1:0]       red_nxt, green_nxt, blue_nxt;

  assign luma  = $signed({19'b0, s3_y_r}) * 27'(crsp_pkg::K_LUMA);
  assign r_acc = luma + s3_ud_r * 27'(crsp_pkg::KR_U) + 27'(crsp_pkg::RND_INV);
  assign g_acc = luma - s3_ud_r * 27'(crsp_pkg::KG_U)
               - s3_vd_r * 27'(crsp_pkg::KG_V) + 27'(crsp_pkg::RND_INV);
  assign b_acc = luma + s3_vd_r * 27'(crsp_pkg::KB_V) + 27'(crsp_pkg::RND_INV);

  assign red_nxt   = s3_byp_r ? s3_r_r : clamp_q16(r_acc);
  assign green_nxt = s3_byp_r ? s3_g_r : clamp_q16(g_acc);
  assign blue_nxt  = s3_byp_r ? s3_b_r : clamp_q16(b_acc);

  logic [W-1:0] red_r, green_r, blue_r;

  always_ff @(posedge clk) begin
    if (adv4) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.red_out   = red_r;
  assign out_ch.green_out = green_r;
  assign out_ch.blue_out  = blue_r;

  `ASSERT_HOLDS(a_full_blocks_input,
    s1_valid_r && s2_valid_r && s3_valid_r && out_valid_r && !out_ch.ready, !in_ch.ready,
    "input taken while every stage is full and output stalled")
  `ASSERT_NEXT(a_stalled_stage_holds,
    s3_valid_r && !adv4, s3_valid_r && $stable(s3_y_r) && $stable(s3_ud_r),
    "stage 3 word lost or changed under stall")
  `ASSERT_NEXT(a_accept_lands,
    in_ch.valid && adv1, s1_valid_r,
    "accepted word missing from stage 1")

endmodule

@@ sv/crsp_rotate.sv @@
// Chroma rotation: centre U/V on 128, rotate by Q1.16 cos/sin, truncate
// toward zero and return each rotated value offset by 384 (Ut + 384).
module crsp_rotate (
  input  logic [crsp_pkg::PIX_W-1:0] u,
  input  logic [crsp_pkg::PIX_W-1:0] v,
  input  crsp_pkg::angle_t           sel,
  output logic [9:0]                 ut_ofs,
  output logic [9:0]                 vt_ofs
);

  logic signed [17:0] cos_c;
  logic signed [17:0] sin_c;
  logic signed [8:0]  du;
  logic signed [8:0]  dv;
  logic signed [27:0] pu;
  logic signed [27:0] pv;
  logic signed [27:0] tu;
  logic signed [27:0] tv;

  always_comb begin
    case (sel)
      crsp_pkg::ANG_45: begin
        cos_c = 18'sd34428;
        sin_c = 18'sd55765;
      end
      crsp_pkg::ANG_135: begin
        cos_c = -18'sd65280;
        sin_c = 18'sd5791;
      end
      // unused selector saturates to the last angle
      default: begin
        cos_c = 18'sd24073;
        sin_c = -18'sd60955;
      end
    endcase
  end

  assign du = $signed({1'b0, u} - 9'd128);
  assign dv = $signed({1'b0, v} - 9'd128);

  assign pu = du * cos_c + dv * sin_c;
  assign pv = dv * cos_c - du * sin_c;

  // round toward zero: bias negative sums before the arithmetic shift
  assign tu = (pu[27] ? (pu + 28'sd65535) : pu) >>> 16;
  assign tv = (pv[27] ? (pv + 28'sd65535) : pv) >>> 16;

  assign ut_ofs = 10'(tu + 28'sd384);
  assign vt_ofs = 10'(tv + 28'sd384);

endmodule
